[sv/assert_macros.svh]
// Assertion macros for the port-level checker of this project.
// Depends on nothing; each file that asserts includes it by name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("%m: implication check failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("%m: next-cycle check failed");

`endif

[sv/dglc_pkg.sv]
// Types and fixed constants for the drive, gimbal and launcher command block.
// No dependencies; imported by the top level and its checker.
package dglc_pkg;

	// Field widths.
	localparam int StickW   = 12;
	localparam int SpeedW   = 14;
	localparam int BandW    = 11;
	localparam int RateW    = 16;
	localparam int LevelW   = 14;
	localparam int TrackW   = 15;
	localparam int ServoW   = 11;
	localparam int DpadW    = 4;
	localparam int CfgDataW = 16;

	// Fixed behavior constants.
	localparam int StickFull  = 2047;
	localparam int StickShift = 11;
	localparam int ServoMin   = 417;
	localparam int ServoMax   = 1083;
	localparam int ServoMid   = 750;
	localparam int TrackLimit = 10000;
	localparam int LaunchKnee = 500;

	localparam logic signed [TrackW-1:0] TrackMax = TrackW'(TrackLimit);
	localparam logic signed [TrackW-1:0] TrackMin = TrackW'(-TrackLimit);

	// Division of the stick product by 2047 is done as a reciprocal multiply.
	localparam int ProdW      = StickW + SpeedW;
	localparam int QuotW      = 16;
	localparam int RecipShift = 36;
	localparam logic [ProdW-1:0] TrackRecip =
		ProdW'((64'd1 << RecipShift) / 64'(StickFull));

	// D-pad key bit positions.
	localparam int DpadUp    = 0;
	localparam int DpadDown  = 1;
	localparam int DpadLeft  = 2;
	localparam int DpadRight = 3;

	// Register reset values.
	localparam logic [SpeedW-1:0] NormalSpeedRst  = SpeedW'(4000);
	localparam logic [SpeedW-1:0] SprintSpeedRst  = SpeedW'(8000);
	localparam logic [BandW-1:0]  DeadBandRst     = BandW'(10);
	localparam logic [RateW-1:0]  GimbalRateRst   = RateW'(356);
	localparam logic [LevelW-1:0] LevelStepRst    = LevelW'(100);
	localparam logic [LevelW-1:0] LevelCeilingRst = LevelW'(1100);
	localparam logic [LevelW-1:0] LevelFloorRst   = LevelW'(500);

	typedef enum logic [2:0] {
		CFG_NORMAL_SPEED    = 3'd0,
		CFG_SPRINT_SPEED    = 3'd1,
		CFG_LEFT_DEAD_BAND  = 3'd2,
		CFG_RIGHT_DEAD_BAND = 3'd3,
		CFG_GIMBAL_RATE     = 3'd4,
		CFG_LEVEL_STEP      = 3'd5,
		CFG_LEVEL_CEILING   = 3'd6,
		CFG_LEVEL_FLOOR     = 3'd7
	} cfg_idx_t;

endpackage

[sv/drive_gimbal_launcher_command.sv]
// Drive, gimbal and launcher command block: one control tick per word.
// Depends on dglc_pkg.
//
//   channel | direction | handshake          | payload
//   in      | to block  | in_valid/in_stall  | four sticks, d-pad, five keys
//   out     | from blk  | out_valid/out_stall| track duties, servo duties, launcher, feed
//   cfg     | to block  | cfg_we             | cfg_index, cfg_data
//
// One word is accepted per cycle while in_stall is low; its result word leaves from the output register.
// The pipe is input register, stick multiply, reciprocal multiply for the divide by
// 2047, quotient correction, then mixing and the state update into the output register.
// Reset is asynchronous and returns registers and state to their defaults at once.
// A stall on the output only holds stages that are full; bubbles still close up.
module drive_gimbal_launcher_command #(
	parameter int GIMBAL_FRACTION_BITS = 16
) (
	input  logic                                       clk,
	input  logic                                       arst_n,
	input  logic                                       in_valid,
	output logic                                       in_stall,
	input  logic signed [dglc_pkg::StickW-1:0]         left_stick_x,
	input  logic signed [dglc_pkg::StickW-1:0]         left_stick_y,
	input  logic signed [dglc_pkg::StickW-1:0]         right_stick_x,
	input  logic signed [dglc_pkg::StickW-1:0]         right_stick_y,
	input  logic        [dglc_pkg::DpadW-1:0]          dpad_keys,
	input  logic                                       sprint_key,
	input  logic                                       level_up_key,
	input  logic                                       level_down_key,
	input  logic                                       launcher_toggle_key,
	input  logic                                       trigger_key,
	output logic                                       out_valid,
	input  logic                                       out_stall,
	output logic signed [dglc_pkg::TrackW-1:0]         left_track_duty,
	output logic signed [dglc_pkg::TrackW-1:0]         right_track_duty,
	output logic        [dglc_pkg::ServoW-1:0]         yaw_servo_duty,
	output logic        [dglc_pkg::ServoW-1:0]         pitch_servo_duty,
	output logic        [dglc_pkg::LevelW-1:0]         launcher_duty,
	output logic                                       feed_pulse,
	input  logic                                       cfg_we,
	input  dglc_pkg::cfg_idx_t                         cfg_index,
	input  logic        [dglc_pkg::CfgDataW-1:0]       cfg_data
);
	import dglc_pkg::*;

	localparam int GimW = StickW + RateW + 1;
	localparam int PosW = ServoW + GIMBAL_FRACTION_BITS;
	localparam int SumW = ((PosW + 1 > GimW) ? PosW + 1 : GimW) + 1;
	localparam int DirW = QuotW + 1;
	localparam int MixW = DirW + 1;
	localparam int RemW = ProdW + 1;

	localparam logic [PosW-1:0] PosRst =
		PosW'(longint'(ServoMid) << GIMBAL_FRACTION_BITS);
	localparam logic signed [SumW-1:0] PosLo =
		SumW'(longint'(ServoMin) << GIMBAL_FRACTION_BITS);
	localparam logic signed [SumW-1:0] PosHi =
		SumW'(longint'(ServoMax) << GIMBAL_FRACTION_BITS);
	localparam logic signed [MixW-1:0] MixMax = MixW'(TrackLimit);
	localparam logic signed [MixW-1:0] MixMin = MixW'(-TrackLimit);
	localparam logic [LevelW-1:0] Knee = LevelW'(LaunchKnee);

	// Configuration registers.
	logic [SpeedW-1:0] normal_speed_q, sprint_speed_q;
	logic [BandW-1:0]  left_band_q, right_band_q;
	logic [RateW-1:0]  gimbal_rate_q;
	logic [LevelW-1:0] level_step_q, level_ceiling_q, level_floor_q;

	// Handshake chain.
	logic valid_s1, valid_s2, valid_s3, valid_s4, out_valid_q;
	logic rdy_s1, rdy_s2, rdy_s3, rdy_s4, rdy_out;

	// Stage 1: registered input word.
	logic signed [StickW-1:0] lx_s1, ly_s1, rx_s1, ry_s1;
	logic [DpadW-1:0] dpad_s1, dpad_s2, dpad_s3;
	logic sprint_s1;
	logic up_s1, down_s1, tog_s1, trig_s1;
	logic up_s2, down_s2, tog_s2, trig_s2;
	logic up_s3, down_s3, tog_s3, trig_s3;
	logic up_s4, down_s4, tog_s4, trig_s4;

	// Stage 2: stick products.
	logic [ProdW-1:0] fwd_prod_s2, turn_prod_s2, fwd_prod_s3, turn_prod_s3;
	logic fwd_neg_s2, turn_neg_s2, fwd_neg_s3, turn_neg_s3;
	logic signed [GimW-1:0] yaw_prod_s2, pitch_prod_s2, yaw_prod_s3, pitch_prod_s3;
	logic signed [GimW-1:0] yaw_prod_s4, pitch_prod_s4;

	// Stage 3: estimated quotients.
	logic [QuotW-1:0] fwd_q0_s3, turn_q0_s3;

	// Stage 4: signed drive commands.
	logic signed [DirW-1:0] fwd_s4, turn_s4;

	// Tick state.
	logic [PosW-1:0]   yaw_pos_q, pitch_pos_q;
	logic [LevelW-1:0] level_q, current_q;
	logic enabled_q, prev_trig_q, prev_up_q, prev_down_q, prev_tog_q;

	// Output register.
	logic signed [TrackW-1:0] left_duty_q, right_duty_q;
	logic [ServoW-1:0] yaw_duty_q, pitch_duty_q;
	logic [LevelW-1:0] launcher_q;
	logic feed_q;

	// Combinational values.
	logic [StickW-1:0] lx_mag, ly_mag, rx_mag, ry_mag;
	logic lx_live, ly_live, rx_live, ry_live;
	logic signed [StickW-1:0] rx_val, ry_val;
	logic [SpeedW-1:0] speed;
	logic [2*ProdW-1:0] fwd_mul, turn_mul;
	logic [RemW-1:0] fwd_rem, turn_rem;
	logic [QuotW-1:0] fwd_quot, turn_quot;
	logic signed [DirW-1:0] fwd_dir, turn_dir, normal_dir;
	logic signed [MixW-1:0] left_mix, right_mix;
	logic signed [TrackW-1:0] left_clamp, right_clamp;
	logic signed [SumW-1:0] yaw_sum, pitch_sum;
	logic [PosW-1:0] yaw_next, pitch_next;
	logic [LevelW:0] level_sum, floor_sum;
	logic [LevelW-1:0] level_next, target, current_next;
	logic enabled_next, feed_next, tick;

	assign rdy_out  = !out_valid_q || !out_stall;
	assign rdy_s4   = !valid_s4 || rdy_out;
	assign rdy_s3   = !valid_s3 || rdy_s4;
	assign rdy_s2   = !valid_s2 || rdy_s3;
	assign rdy_s1   = !valid_s1 || rdy_s2;
	assign in_stall = !rdy_s1;
	assign tick     = valid_s4 && rdy_out;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			normal_speed_q  <= NormalSpeedRst;
			sprint_speed_q  <= SprintSpeedRst;
			left_band_q     <= DeadBandRst;
			right_band_q    <= DeadBandRst;
			gimbal_rate_q   <= GimbalRateRst;
			level_step_q    <= LevelStepRst;
			level_ceiling_q <= LevelCeilingRst;
			level_floor_q   <= LevelFloorRst;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_NORMAL_SPEED:    normal_speed_q  <= cfg_data[SpeedW-1:0];
				CFG_SPRINT_SPEED:    sprint_speed_q  <= cfg_data[SpeedW-1:0];
				CFG_LEFT_DEAD_BAND:  left_band_q     <= cfg_data[BandW-1:0];
				CFG_RIGHT_DEAD_BAND: right_band_q    <= cfg_data[BandW-1:0];
				CFG_GIMBAL_RATE:     gimbal_rate_q   <= cfg_data[RateW-1:0];
				CFG_LEVEL_STEP:      level_step_q    <= cfg_data[LevelW-1:0];
				CFG_LEVEL_CEILING:   level_ceiling_q <= cfg_data[LevelW-1:0];
				CFG_LEVEL_FLOOR:     level_floor_q   <= cfg_data[LevelW-1:0];
				default:             normal_speed_q  <= normal_speed_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			valid_s3    <= 1'b0;
			valid_s4    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (rdy_s1) valid_s1 <= in_valid;
			if (rdy_s2) valid_s2 <= valid_s1;
			if (rdy_s3) valid_s3 <= valid_s2;
			if (rdy_s4) valid_s4 <= valid_s3;
			if (rdy_out) out_valid_q <= valid_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s1 && in_valid) begin
			lx_s1     <= left_stick_x;
			ly_s1     <= left_stick_y;
			rx_s1     <= right_stick_x;
			ry_s1     <= right_stick_y;
			dpad_s1   <= dpad_keys;
			sprint_s1 <= sprint_key;
			up_s1     <= level_up_key;
			down_s1   <= level_down_key;
			tog_s1    <= launcher_toggle_key;
			trig_s1   <= trigger_key;
		end
	end

	// Dead band and stick products. A stick at its most negative code has magnitude
	// 2048, which the unsigned 12-bit magnitude holds.
	always_comb begin
		lx_mag  = lx_s1[StickW-1] ? StickW'(-lx_s1) : lx_s1;
		ly_mag  = ly_s1[StickW-1] ? StickW'(-ly_s1) : ly_s1;
		rx_mag  = rx_s1[StickW-1] ? StickW'(-rx_s1) : rx_s1;
		ry_mag  = ry_s1[StickW-1] ? StickW'(-ry_s1) : ry_s1;
		lx_live = lx_mag > StickW'(left_band_q);
		ly_live = ly_mag > StickW'(left_band_q);
		rx_live = rx_mag > StickW'(right_band_q);
		ry_live = ry_mag > StickW'(right_band_q);
		rx_val  = rx_live ? rx_s1 : '0;
		ry_val  = ry_live ? ry_s1 : '0;
		speed   = sprint_s1 ? sprint_speed_q : normal_speed_q;
	end

	always_ff @(posedge clk) begin
		if (rdy_s2 && valid_s1) begin
			fwd_prod_s2   <= ly_live ? ProdW'(ly_mag) * ProdW'(speed) : '0;
			turn_prod_s2  <= lx_live ? ProdW'(lx_mag) * ProdW'(speed) : '0;
			fwd_neg_s2    <= ly_s1[StickW-1];
			turn_neg_s2   <= lx_s1[StickW-1];
			yaw_prod_s2   <= GimW'(rx_val) * GimW'($signed({1'b0, gimbal_rate_q}));
			pitch_prod_s2 <= GimW'(ry_val) * GimW'($signed({1'b0, gimbal_rate_q}));
			dpad_s2       <= dpad_s1;
			up_s2         <= up_s1;
			down_s2       <= down_s1;
			tog_s2        <= tog_s1;
			trig_s2       <= trig_s1;
		end
	end

	// The reciprocal is rounded down, so the estimate is the true quotient or one less.
	assign fwd_mul  = (2 * ProdW)'(fwd_prod_s2) * (2 * ProdW)'(TrackRecip);
	assign turn_mul = (2 * ProdW)'(turn_prod_s2) * (2 * ProdW)'(TrackRecip);

	always_ff @(posedge clk) begin
		if (rdy_s3 && valid_s2) begin
			fwd_q0_s3     <= fwd_mul[RecipShift +: QuotW];
			turn_q0_s3    <= turn_mul[RecipShift +: QuotW];
			fwd_prod_s3   <= fwd_prod_s2;
			turn_prod_s3  <= turn_prod_s2;
			fwd_neg_s3    <= fwd_neg_s2;
			turn_neg_s3   <= turn_neg_s2;
			yaw_prod_s3   <= yaw_prod_s2;
			pitch_prod_s3 <= pitch_prod_s2;
			dpad_s3       <= dpad_s2;
			up_s3         <= up_s2;
			down_s3       <= down_s2;
			tog_s3        <= tog_s2;
			trig_s3       <= trig_s2;
		end
	end

	// Quotient correction, sign restore (truncation toward zero) and d-pad override.
	always_comb begin
		fwd_rem    = RemW'(fwd_prod_s3) - (RemW'(fwd_q0_s3) << StickShift)
			+ RemW'(fwd_q0_s3);
		turn_rem   = RemW'(turn_prod_s3) - (RemW'(turn_q0_s3) << StickShift)
			+ RemW'(turn_q0_s3);
		fwd_quot   = (fwd_rem >= RemW'(StickFull)) ? fwd_q0_s3 + 1'b1 : fwd_q0_s3;
		turn_quot  = (turn_rem >= RemW'(StickFull)) ? turn_q0_s3 + 1'b1 : turn_q0_s3;
		normal_dir = DirW'(normal_speed_q);
		fwd_dir    = fwd_neg_s3 ? -$signed(DirW'(fwd_quot)) : $signed(DirW'(fwd_quot));
		turn_dir   = turn_neg_s3 ? -$signed(DirW'(turn_quot)) : $signed(DirW'(turn_quot));
		// Down wins over up, right wins over left.
		if (dpad_s3[DpadDown]) begin
			fwd_dir = -normal_dir;
		end else if (dpad_s3[DpadUp]) begin
			fwd_dir = normal_dir;
		end
		if (dpad_s3[DpadRight]) begin
			turn_dir = normal_dir;
		end else if (dpad_s3[DpadLeft]) begin
			turn_dir = -normal_dir;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s4 && valid_s3) begin
			fwd_s4        <= fwd_dir;
			turn_s4       <= turn_dir;
			yaw_prod_s4   <= yaw_prod_s3;
			pitch_prod_s4 <= pitch_prod_s3;
			up_s4         <= up_s3;
			down_s4       <= down_s3;
			tog_s4        <= tog_s3;
			trig_s4       <= trig_s3;
		end
	end

	// Track mixing and clamp.
	always_comb begin
		left_mix  = -MixW'(fwd_s4) - MixW'(turn_s4);
		right_mix = MixW'(fwd_s4) - MixW'(turn_s4);
		if (left_mix > MixMax) begin
			left_clamp = TrackMax;
		end else if (left_mix < MixMin) begin
			left_clamp = TrackMin;
		end else begin
			left_clamp = left_mix[TrackW-1:0];
		end
		if (right_mix > MixMax) begin
			right_clamp = TrackMax;
		end else if (right_mix < MixMin) begin
			right_clamp = TrackMin;
		end else begin
			right_clamp = right_mix[TrackW-1:0];
		end
	end

	// Gimbal integration with clamp.
	always_comb begin
		yaw_sum   = $signed(SumW'(yaw_pos_q)) + SumW'(yaw_prod_s4);
		pitch_sum = $signed(SumW'(pitch_pos_q)) + SumW'(pitch_prod_s4);
		if (yaw_sum < PosLo) begin
			yaw_next = PosW'(PosLo);
		end else if (yaw_sum > PosHi) begin
			yaw_next = PosW'(PosHi);
		end else begin
			yaw_next = yaw_sum[PosW-1:0];
		end
		if (pitch_sum < PosLo) begin
			pitch_next = PosW'(PosLo);
		end else if (pitch_sum > PosHi) begin
			pitch_next = PosW'(PosHi);
		end else begin
			pitch_next = pitch_sum[PosW-1:0];
		end
	end

	// Launcher level, on/off, ramp and feed. Up is applied before down.
	always_comb begin
		level_next = level_q;
		level_sum  = {1'b0, level_q} + {1'b0, level_step_q};
		if (up_s4 && !prev_up_q) begin
			level_next = (level_sum <= {1'b0, level_ceiling_q}) ? level_sum[LevelW-1:0]
				: level_ceiling_q;
		end
		floor_sum = {1'b0, level_floor_q} + {1'b0, level_step_q};
		if (down_s4 && !prev_down_q) begin
			level_next = ({1'b0, level_next} >= floor_sum) ? level_next - level_step_q
				: level_floor_q;
		end
		enabled_next = enabled_q ^ (tog_s4 && !prev_tog_q);
		target       = enabled_next ? level_next : '0;
		feed_next    = trig_s4 && !prev_trig_q;
		priority if (target >= Knee && current_q < Knee) begin
			current_next = Knee;
		end else if (current_q < target) begin
			current_next = current_q + 1'b1;
		end else if (current_q > target) begin
			current_next = (current_q <= Knee && target == '0) ? '0 : current_q - 1'b1;
		end else begin
			current_next = current_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			yaw_pos_q   <= PosRst;
			pitch_pos_q <= PosRst;
			level_q     <= LevelCeilingRst;
			current_q   <= '0;
			enabled_q   <= 1'b0;
			prev_trig_q <= 1'b0;
			prev_up_q   <= 1'b0;
			prev_down_q <= 1'b0;
			prev_tog_q  <= 1'b0;
		end else if (tick) begin
			yaw_pos_q   <= yaw_next;
			pitch_pos_q <= pitch_next;
			level_q     <= level_next;
			current_q   <= current_next;
			enabled_q   <= enabled_next;
			prev_trig_q <= trig_s4;
			prev_up_q   <= up_s4;
			prev_down_q <= down_s4;
			prev_tog_q  <= tog_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (tick) begin
			left_duty_q  <= left_clamp;
			right_duty_q <= right_clamp;
			yaw_duty_q   <= yaw_next[PosW-1:GIMBAL_FRACTION_BITS];
			pitch_duty_q <= pitch_next[PosW-1:GIMBAL_FRACTION_BITS];
			launcher_q   <= current_next;
			feed_q       <= feed_next;
		end
	end

	assign out_valid        = out_valid_q;
	assign left_track_duty  = left_duty_q;
	assign right_track_duty = right_duty_q;
	assign yaw_servo_duty   = yaw_duty_q;
	assign pitch_servo_duty = pitch_duty_q;
	assign launcher_duty    = launcher_q;
	assign feed_pulse       = feed_q;

endmodule

[sv/dglc_checker.sv]
// Port-level checker for the drive, gimbal and launcher command block, and its bind.
// Depends on dglc_pkg and assert_macros.svh.
`include "assert_macros.svh"

module dglc_checker (
	input logic                               clk,
	input logic                               arst_n,
	input logic                               out_valid,
	input logic                               out_stall,
	input logic signed [dglc_pkg::TrackW-1:0] left_track_duty,
	input logic signed [dglc_pkg::TrackW-1:0] right_track_duty,
	input logic        [dglc_pkg::ServoW-1:0] yaw_servo_duty,
	input logic        [dglc_pkg::ServoW-1:0] pitch_servo_duty,
	input logic        [dglc_pkg::LevelW-1:0] launcher_duty,
	input logic                               feed_pulse
);
	import dglc_pkg::*;

	// Both track duties stay inside the clamp.
	`ASSERT_IMPL(a_track_range, clk, arst_n, out_valid, (left_track_duty >= TrackMin && left_track_duty <= TrackMax && right_track_duty >= TrackMin && right_track_duty <= TrackMax))

	// Both servo duties stay inside the servo travel.
	`ASSERT_IMPL(a_servo_range, clk, arst_n, out_valid, (yaw_servo_duty >= ServoW'(ServoMin) && yaw_servo_duty <= ServoW'(ServoMax) && pitch_servo_duty >= ServoW'(ServoMin) && pitch_servo_duty <= ServoW'(ServoMax)))

	// A feed pulse needs a released trigger first, so two consecutive delivered words never both fire.
	`ASSERT_NEXT(a_feed_single, clk, arst_n, (out_valid && !out_stall && feed_pulse), !(out_valid && feed_pulse))

	// A held result word keeps its left track duty, launcher duty and feed pulse.
	`ASSERT_NEXT(a_out_hold, clk, arst_n, (out_valid && out_stall), (out_valid && $stable(left_track_duty) && $stable(launcher_duty) && $stable(feed_pulse)))

endmodule

bind drive_gimbal_launcher_command dglc_checker u_dglc_checker (.*);

[bench/command_checker.sv]
// Checker for the drive, gimbal and launcher command block: predicts the result word of
// every accepted tick word and compares it with the block's output word.
// Depends on dglc_pkg; instantiated by testbench beside the block.
`timescale 1ns / 1ps
module command_checker (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	input  logic                                 in_stall,
	input  logic signed [dglc_pkg::StickW-1:0]   left_stick_x,
	input  logic signed [dglc_pkg::StickW-1:0]   left_stick_y,
	input  logic signed [dglc_pkg::StickW-1:0]   right_stick_x,
	input  logic signed [dglc_pkg::StickW-1:0]   right_stick_y,
	input  logic        [dglc_pkg::DpadW-1:0]    dpad_keys,
	input  logic                                 sprint_key,
	input  logic                                 level_up_key,
	input  logic                                 level_down_key,
	input  logic                                 launcher_toggle_key,
	input  logic                                 trigger_key,
	input  logic                                 out_valid,
	input  logic                                 out_stall,
	input  logic signed [dglc_pkg::TrackW-1:0]   left_track_duty,
	input  logic signed [dglc_pkg::TrackW-1:0]   right_track_duty,
	input  logic        [dglc_pkg::ServoW-1:0]   yaw_servo_duty,
	input  logic        [dglc_pkg::ServoW-1:0]   pitch_servo_duty,
	input  logic        [dglc_pkg::LevelW-1:0]   launcher_duty,
	input  logic                                 feed_pulse,
	input  logic                                 cfg_we,
	input  dglc_pkg::cfg_idx_t                   cfg_index,
	input  logic        [dglc_pkg::CfgDataW-1:0] cfg_data,
	output int                                   mismatches,
	output int                                   pending_ticks
);
	import dglc_pkg::*;

	localparam int FracBits = 16;

	typedef struct packed {
		logic signed [TrackW-1:0] left_duty;
		logic signed [TrackW-1:0] right_duty;
		logic        [ServoW-1:0] yaw_duty;
		logic        [ServoW-1:0] pitch_duty;
		logic        [LevelW-1:0] wheel_duty_out;
		logic                     feed;
	} command_t;

	command_t awaited_cmds [$];
	command_t want;
	int errs = 0;

	// Register copies.
	int normal_spd, sprint_spd, left_band, right_band, slew_rate;
	int lvl_step, lvl_ceiling, lvl_floor;

	// Block state.
	longint yaw_pos, pitch_pos;
	int lvl, wheel_duty;
	bit wheel_on, last_trig, last_up, last_down, last_toggle;

	assign mismatches = errs;

	function automatic int dead_zone(input int v, input int band);
		int m;
		m = (v < 0) ? -v : v;
		return (m <= band) ? 0 : v;
	endfunction

	// Signed division truncates toward zero, as the duty scaling requires.
	function automatic int stick_to_duty(input int v, input int speed);
		longint p;
		p = longint'(v) * longint'(speed);
		return int'(p / StickFull);
	endfunction

	function automatic int limit_track(input int v);
		if (v < -TrackLimit) return -TrackLimit;
		if (v > TrackLimit) return TrackLimit;
		return v;
	endfunction

	function automatic longint step_servo(input longint pos, input int v);
		longint lo, hi;
		lo = longint'(ServoMin) <<< FracBits;
		hi = longint'(ServoMax) <<< FracBits;
		pos += longint'(v) * longint'(slew_rate);
		if (pos < lo) pos = lo;
		if (pos > hi) pos = hi;
		return pos;
	endfunction

	function automatic command_t advance_tick(
		input logic signed [StickW-1:0] lx_in, ly_in, rx_in, ry_in,
		input logic [DpadW-1:0] dpad,
		input bit sprint, up, down, toggle, trig
	);
		int lx, ly, rx, ry, speed, fwd, turn, target;
		command_t c;
		lx = dead_zone(int'(lx_in), left_band);
		ly = dead_zone(int'(ly_in), left_band);
		rx = dead_zone(int'(rx_in), right_band);
		ry = dead_zone(int'(ry_in), right_band);
		speed = sprint ? sprint_spd : normal_spd;
		fwd = stick_to_duty(ly, speed);
		turn = stick_to_duty(lx, speed);
		// The later key wins: down over up, right over left.
		if (dpad[DpadUp]) fwd = normal_spd;
		if (dpad[DpadDown]) fwd = -normal_spd;
		if (dpad[DpadLeft]) turn = -normal_spd;
		if (dpad[DpadRight]) turn = normal_spd;

		yaw_pos = step_servo(yaw_pos, rx);
		pitch_pos = step_servo(pitch_pos, ry);

		if (up && !last_up) lvl = (lvl + lvl_step <= lvl_ceiling) ? lvl + lvl_step : lvl_ceiling;
		if (down && !last_down) lvl = (lvl >= lvl_floor + lvl_step) ? lvl - lvl_step : lvl_floor;
		if (toggle && !last_toggle) wheel_on = !wheel_on;
		last_up = up;
		last_down = down;
		last_toggle = toggle;
		target = wheel_on ? lvl : 0;

		if (target >= LaunchKnee && wheel_duty < LaunchKnee) wheel_duty = LaunchKnee;
		else if (wheel_duty < target) wheel_duty++;
		else if (wheel_duty > target) begin
			if (wheel_duty <= LaunchKnee && target == 0) wheel_duty = 0;
			else wheel_duty--;
		end

		c.left_duty = TrackW'(limit_track(-fwd - turn));
		c.right_duty = TrackW'(limit_track(fwd - turn));
		c.yaw_duty = ServoW'(yaw_pos >>> FracBits);
		c.pitch_duty = ServoW'(pitch_pos >>> FracBits);
		c.wheel_duty_out = LevelW'(wheel_duty);
		c.feed = trig && !last_trig;
		last_trig = trig;
		return c;
	endfunction

	task automatic check_field(input string name, input int want_v, got_v);
		if (got_v !== want_v) begin
			$error("%s: expected %0d, got %0d", name, want_v, got_v);
			errs++;
		end
	endtask

	always @(posedge clk) begin
		if (!arst_n) begin
			normal_spd = int'(NormalSpeedRst);
			sprint_spd = int'(SprintSpeedRst);
			left_band = int'(DeadBandRst);
			right_band = int'(DeadBandRst);
			slew_rate = int'(GimbalRateRst);
			lvl_step = int'(LevelStepRst);
			lvl_ceiling = int'(LevelCeilingRst);
			lvl_floor = int'(LevelFloorRst);
			yaw_pos = longint'(ServoMid) <<< FracBits;
			pitch_pos = yaw_pos;
			lvl = int'(LevelCeilingRst);
			wheel_duty = 0;
			wheel_on = 1'b0;
			last_trig = 1'b0;
			last_up = 1'b0;
			last_down = 1'b0;
			last_toggle = 1'b0;
			awaited_cmds.delete();
			pending_ticks <= 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_NORMAL_SPEED: normal_spd = int'(cfg_data[SpeedW-1:0]);
					CFG_SPRINT_SPEED: sprint_spd = int'(cfg_data[SpeedW-1:0]);
					CFG_LEFT_DEAD_BAND: left_band = int'(cfg_data[BandW-1:0]);
					CFG_RIGHT_DEAD_BAND: right_band = int'(cfg_data[BandW-1:0]);
					CFG_GIMBAL_RATE: slew_rate = int'(cfg_data[RateW-1:0]);
					CFG_LEVEL_STEP: lvl_step = int'(cfg_data[LevelW-1:0]);
					CFG_LEVEL_CEILING: lvl_ceiling = int'(cfg_data[LevelW-1:0]);
					CFG_LEVEL_FLOOR: lvl_floor = int'(cfg_data[LevelW-1:0]);
					default: ;
				endcase
			end
			// Results leave only after passing the block's pipe registers, so pop before push.
			if (out_valid && !out_stall) begin
				if (awaited_cmds.size() == 0) begin
					$error("result word arrived with no tick waiting");
					errs++;
				end else begin
					want = awaited_cmds.pop_front();
					check_field("left_track_duty", int'($signed(want.left_duty)),
						int'(left_track_duty));
					check_field("right_track_duty", int'($signed(want.right_duty)),
						int'(right_track_duty));
					check_field("yaw_servo_duty", int'(want.yaw_duty), int'(yaw_servo_duty));
					check_field("pitch_servo_duty", int'(want.pitch_duty),
						int'(pitch_servo_duty));
					check_field("launcher_duty", int'(want.wheel_duty_out),
						int'(launcher_duty));
					check_field("feed_pulse", int'(want.feed), int'(feed_pulse));
				end
			end
			if (in_valid && !in_stall)
				awaited_cmds.push_back(advance_tick(left_stick_x, left_stick_y,
					right_stick_x, right_stick_y, dpad_keys, sprint_key, level_up_key,
					level_down_key, launcher_toggle_key, trigger_key));
			pending_ticks <= awaited_cmds.size();
		end
	end

endmodule

[bench/testbench.sv]
// Top of the bench for drive_gimbal_launcher_command: clock, reset, tick words, output
// stalls and register settings; command_checker does the prediction and comparison.
// Depends on dglc_pkg, drive_gimbal_launcher_command and command_checker.
`timescale 1ns / 1ps
module testbench;
	import dglc_pkg::*;

	localparam int CycleLimit = 400000;

	localparam logic [4:0] KeySprint = 5'b10000;
	localparam logic [4:0] KeyUp     = 5'b01000;
	localparam logic [4:0] KeyDown   = 5'b00100;
	localparam logic [4:0] KeyToggle = 5'b00010;
	localparam logic [4:0] KeyTrig   = 5'b00001;

	localparam logic [DpadW-1:0] DpUp    = DpadW'(1 << DpadUp);
	localparam logic [DpadW-1:0] DpDown  = DpadW'(1 << DpadDown);
	localparam logic [DpadW-1:0] DpLeft  = DpadW'(1 << DpadLeft);
	localparam logic [DpadW-1:0] DpRight = DpadW'(1 << DpadRight);

	typedef struct packed {
		logic [StickW-1:0] lx;
		logic [StickW-1:0] ly;
		logic [StickW-1:0] rx;
		logic [StickW-1:0] ry;
		logic [DpadW-1:0]  dpad;
		logic [4:0]        keys;
	} tick_t;

	typedef struct packed {
		logic [CfgDataW-1:0] normal;
		logic [CfgDataW-1:0] sprint;
		logic [CfgDataW-1:0] left_band;
		logic [CfgDataW-1:0] right_band;
		logic [CfgDataW-1:0] rate;
		logic [CfgDataW-1:0] step;
		logic [CfgDataW-1:0] ceiling;
		logic [CfgDataW-1:0] floor_level;
	} reg_set_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic signed [StickW-1:0] left_stick_x = '0;
	logic signed [StickW-1:0] left_stick_y = '0;
	logic signed [StickW-1:0] right_stick_x = '0;
	logic signed [StickW-1:0] right_stick_y = '0;
	logic [DpadW-1:0] dpad_keys = '0;
	logic sprint_key = 1'b0;
	logic level_up_key = 1'b0;
	logic level_down_key = 1'b0;
	logic launcher_toggle_key = 1'b0;
	logic trigger_key = 1'b0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic signed [TrackW-1:0] left_track_duty, right_track_duty;
	logic [ServoW-1:0] yaw_servo_duty, pitch_servo_duty;
	logic [LevelW-1:0] launcher_duty;
	logic feed_pulse;
	logic cfg_we = 1'b0;
	cfg_idx_t cfg_index = CFG_NORMAL_SPEED;
	logic [CfgDataW-1:0] cfg_data = '0;
	int mismatches, pending_ticks;
	logic squeeze_req = 1'b0;
	int cycle_count = 0;
	logic [4:0] held_keys = '0;

	drive_gimbal_launcher_command uut (.*);
	command_checker checker_i (.*);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CycleLimit) begin
			$display("Mismatches found");
			$finish;
		end
	end

	function automatic tick_t tick_of(input int lx, ly, rx, ry,
		input logic [DpadW-1:0] dp, input logic [4:0] k);
		tick_t t;
		t.lx = StickW'(lx);
		t.ly = StickW'(ly);
		t.rx = StickW'(rx);
		t.ry = StickW'(ry);
		t.dpad = dp;
		t.keys = k;
		return t;
	endfunction

	function automatic logic [StickW-1:0] random_stick();
		int sel;
		sel = $urandom_range(0, 9);
		if (sel < 4) return StickW'($urandom);
		if (sel < 8) return StickW'(int'($urandom_range(0, 120)) - 60);
		case ($urandom_range(0, 3))
			0: return StickW'(-2048);
			1: return StickW'(-StickFull);
			2: return StickW'(StickFull);
			default: return '0;
		endcase
	endfunction

	// Keys are held across ticks and flip now and then, so presses have real edges.
	function automatic tick_t random_tick();
		tick_t t;
		t.lx = random_stick();
		t.ly = random_stick();
		t.rx = random_stick();
		t.ry = random_stick();
		t.dpad = ($urandom_range(0, 9) < 7) ? '0 : DpadW'($urandom);
		if ($urandom_range(0, 3) == 0) held_keys ^= KeySprint;
		if ($urandom_range(0, 2) == 0) held_keys ^= KeyUp;
		if ($urandom_range(0, 2) == 0) held_keys ^= KeyDown;
		if ($urandom_range(0, 9) == 0) held_keys ^= KeyToggle;
		if ($urandom_range(0, 1) == 0) held_keys ^= KeyTrig;
		t.keys = held_keys;
		return t;
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 93) return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	function automatic reg_set_t random_set();
		reg_set_t s;
		s.normal = CfgDataW'($urandom_range(0, 10000));
		s.sprint = CfgDataW'($urandom_range(0, 10000));
		s.left_band = CfgDataW'($urandom_range(0, 200));
		s.right_band = CfgDataW'($urandom_range(0, 200));
		s.rate = CfgDataW'($urandom_range(0, 65535));
		s.step = CfgDataW'($urandom_range(1, 400));
		s.ceiling = CfgDataW'($urandom_range(500, 3000));
		s.floor_level = CfgDataW'($urandom_range(0, 900));
		return s;
	endfunction

	task automatic send_word(input tick_t t, input int gap);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		left_stick_x <= t.lx;
		left_stick_y <= t.ly;
		right_stick_x <= t.rx;
		right_stick_y <= t.ry;
		dpad_keys <= t.dpad;
		sprint_key <= |(t.keys & KeySprint);
		level_up_key <= |(t.keys & KeyUp);
		level_down_key <= |(t.keys & KeyDown);
		launcher_toggle_key <= |(t.keys & KeyToggle);
		trigger_key <= |(t.keys & KeyTrig);
		@(posedge clk);
		while (in_stall) @(posedge clk);
	endtask

	task automatic write_reg(input cfg_idx_t idx, input logic [CfgDataW-1:0] value);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
	endtask

	task automatic program_regs(input reg_set_t s);
		write_reg(CFG_NORMAL_SPEED, s.normal);
		write_reg(CFG_SPRINT_SPEED, s.sprint);
		write_reg(CFG_LEFT_DEAD_BAND, s.left_band);
		write_reg(CFG_RIGHT_DEAD_BAND, s.right_band);
		write_reg(CFG_GIMBAL_RATE, s.rate);
		write_reg(CFG_LEVEL_STEP, s.step);
		write_reg(CFG_LEVEL_CEILING, s.ceiling);
		write_reg(CFG_LEVEL_FLOOR, s.floor_level);
		cfg_we <= 1'b0;
	endtask

	// The pending count is registered, so let it update before trusting it.
	task automatic settle();
		@(posedge clk);
		while (pending_ticks != 0) @(posedge clk);
		repeat (10) @(posedge clk);
	endtask

	task automatic run_random(input int count, input bit squeeze);
		bit calm;
		calm = 1'b0;
		if (squeeze) squeeze_req <= 1'b1;
		for (int n = 0; n < count; n++) begin
			if (n % 32 == 0) calm = ($urandom_range(0, 3) == 0);
			send_word(random_tick(), calm ? 0 : pick_gap());
		end
		in_valid <= 1'b0;
	endtask

	// Output side: short and long stalls, free stretches, and one long hold-off.
	initial begin
		int free_run, hold;
		bit squeezed;
		squeezed = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (squeeze_req && !squeezed) begin
				out_stall <= 1'b1;
				repeat (200) @(posedge clk);
				squeezed = 1'b1;
			end else begin
				free_run = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 150)
					: $urandom_range(1, 8);
				out_stall <= 1'b0;
				repeat (free_run) begin
					@(posedge clk);
					if (squeeze_req && !squeezed) break;
				end
				hold = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
					: $urandom_range(1, 3);
				out_stall <= 1'b1;
				repeat (hold) @(posedge clk);
			end
		end
	end

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed ticks at the reset register values.
		send_word(tick_of(0, 0, 0, 0, '0, '0), pick_gap());
		send_word(tick_of(2047, 2047, 2047, 2047, '0, KeySprint), pick_gap());
		send_word(tick_of(-2047, -2047, -2047, -2047, '0, KeyTrig), pick_gap());
		send_word(tick_of(-2048, -2048, -2048, -2048, '0, KeyTrig), pick_gap());
		send_word(tick_of(10, -10, 10, -10, '0, '0), pick_gap());
		send_word(tick_of(11, -11, 11, -11, '0, '0), pick_gap());
		send_word(tick_of(0, 0, 0, 0, DpUp, '0), pick_gap());
		send_word(tick_of(0, 0, 0, 0, DpDown, '0), pick_gap());
		send_word(tick_of(0, 0, 0, 0, DpLeft, '0), pick_gap());
		send_word(tick_of(0, 0, 0, 0, DpRight, '0), pick_gap());
		send_word(tick_of(500, 0, 0, 0, DpUp | DpDown, '0), pick_gap());
		send_word(tick_of(0, -500, 0, 0, DpLeft | DpRight, '0), pick_gap());
		send_word(tick_of(1000, 1000, 0, 0, DpUp | DpDown | DpLeft | DpRight, KeySprint),
			pick_gap());
		// Launcher on jumps to the knee; off right after falls to the knee, then cuts out.
		send_word(tick_of(0, 0, 0, 0, '0, KeyToggle), pick_gap());
		send_word(tick_of(0, 0, 0, 0, '0, KeyUp), pick_gap());
		send_word(tick_of(0, 0, 0, 0, '0, KeyToggle | KeyDown), pick_gap());
		send_word(tick_of(0, 0, 0, 0, '0, '0), pick_gap());
		send_word(tick_of(0, 0, 0, 0, '0, KeyUp | KeyDown), pick_gap());
		send_word(tick_of(0, 0, 0, 0, '0, KeyToggle), pick_gap());
		send_word(tick_of(0, 0, 0, 0, '0, '0), pick_gap());
		send_word(tick_of(0, 0, 0, 0, '0, KeyTrig), pick_gap());
		send_word(tick_of(0, 0, 0, 0, '0, '0), pick_gap());
		in_valid <= 1'b0;
		settle();

		program_regs(reg_set_t'{16'd4000, 16'd8000, 16'd10, 16'd10, 16'd356, 16'd100,
			16'd1100, 16'd500});
		run_random(120, 1'b1);
		settle();

		program_regs(reg_set_t'{16'd10000, 16'd10000, 16'd0, 16'd0, 16'd65535, 16'd10000,
			16'd10000, 16'd10000});
		run_random(100, 1'b0);
		settle();

		program_regs(reg_set_t'{16'd0, 16'd0, 16'd2047, 16'd2047, 16'd0, 16'd0, 16'd0, 16'd0});
		run_random(100, 1'b0);
		settle();

		// Upper bits beyond each register's width are dropped by the block.
		program_regs(reg_set_t'{16'hFFFF, 16'hC123, 16'hF800, 16'hFFFF, 16'd1, 16'hFFFF,
			16'h3FFF, 16'h0000});
		run_random(100, 1'b0);
		settle();

		program_regs(random_set());
		run_random(100, 1'b0);
		settle();

		program_regs(random_set());
		run_random(100, 1'b0);
		settle();

		if (mismatches == 0) $display("No mismatches found");
		else $display("Mismatches found");
		$finish;
	end

endmodule

[filelist.f]
+incdir+sv
sv/dglc_pkg.sv
sv/drive_gimbal_launcher_command.sv
sv/dglc_checker.sv
bench/command_checker.sv
bench/testbench.sv
